/* design/chkc_pkg.sv */
package chkc_pkg;

  // Field widths of the channels and the configuration port.
  localparam int KEY_W      = 64;
  localparam int COUNT_W    = 32;
  localparam int ECOUNT_W   = 14;
  localparam int MULT_W     = 32;
  localparam int BCOUNT_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Operation codes carried in the mode field.
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_THRESH = 2'd1,
    MODE_COUNT  = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCOUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd2;

  // Register values after reset.
  localparam logic [MULT_W-1:0]   MULT_RESET   = 32'd2654435761;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 13'd4096;
  localparam logic [COUNT_W-1:0]  THRESH_RESET = 32'd0;

  localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;

endpackage

/* design/chkc_in_if.sv */
interface chkc_in_if;
  import chkc_pkg::*;

  logic                valid;
  logic                ready;
  mode_t               mode;
  logic [KEY_W-1:0]    key;
  logic [COUNT_W-1:0]  initial_count;

  modport source (output valid, mode, key, initial_count, input ready);
  modport sink   (input valid, mode, key, initial_count, output ready);
endinterface

/* design/chkc_out_if.sv */
interface chkc_out_if;
  import chkc_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic                table_full;
  logic [ECOUNT_W-1:0] entry_count;

  modport source (output valid, hit, table_full, entry_count, input ready);
  modport sink   (input valid, hit, table_full, entry_count, output ready);
endinterface

/* design/chained_hash_kmer_counter_core.sv */
// Chained hash table that counts packed 64-bit keys over a fixed entry pool.
// in_ch carries one beat per operation (mode, key, initial_count); out_ch
// returns exactly one beat per operation (hit, table_full, entry_count).
// The cfg port writes hash_multiplier, bucket_count and count_threshold by index;
// the user must write them only while the block is idle; it does not enforce this.
// One operation is handled at a time. An insert or search runs the 64x32
// multiply (two 32x32 partial products), the modulo unit (4 quotient bits
// per cycle) and a read of the bucket head memory; a search then reads the
// entry memory for each chain entry visited, and a last step presents the
// result. A rejected insert (pool full) skips the hash and goes straight to
// the result step.
// A clear, and every reset, sweeps the bucket head memory one bucket a
// cycle across all BUCKETS (4096 by default), during which in_ch.ready is low.
// Results sit in an output register. If out_ch stalls, the next beat can
// still be accepted and worked on; it then waits in its last step, with
// in_ch.ready low, until the output register has been taken.
module chained_hash_kmer_counter_core #(
  parameter int BUCKETS = 4096,
  parameter int POOL    = 8192
) (
  input  logic                               clk,
  input  logic                               rst,
  chkc_in_if.sink                            in_ch,
  chkc_out_if.source                         out_ch,
  input  logic                               cfg_we,
  input  logic [chkc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [chkc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import chkc_pkg::*;

  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NBW = BW + 1;
  localparam int PAW = (POOL > 1) ? $clog2(POOL) : 1;
  localparam int LW  = PAW + 1;
  localparam int EW  = KEY_W + COUNT_W + LW;
  localparam logic [LW-1:0] EMPTY_LINK = LW'(POOL);

  typedef enum logic [9:0] {
    S_SWEEP = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MLO   = 10'b0000000100,
    S_MHI   = 10'b0000001000,
    S_DIV   = 10'b0000010000,
    S_HEAD  = 10'b0000100000,
    S_HDAT  = 10'b0001000000,
    S_WALK  = 10'b0010000000,
    S_WCHK  = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [MULT_W-1:0]   hash_multiplier;
  logic [BCOUNT_W-1:0] bucket_count;
  logic [COUNT_W-1:0]  count_threshold;

  // Operation being worked on.
  mode_t              op_mode;
  logic [KEY_W-1:0]   op_key;
  logic [COUNT_W-1:0] op_init;
  logic [KEY_W-1:0]   fold;
  logic [KEY_W-1:0]   prod;
  logic [NBW-1:0]     rem;
  logic [3:0]         div_cnt;
  logic [LW-1:0]      node;
  logic [LW-1:0]      used;
  logic [BW-1:0]      sweep_idx;
  logic               sweep_item;
  logic               res_hit;
  logic               res_full;

  // Output register.
  logic                out_valid;
  logic                out_hit;
  logic                out_full;
  logic [ECOUNT_W-1:0] out_count;

  // Memories: bucket heads and the entry pool {key, count, link}.
  logic [LW-1:0] head_mem [BUCKETS];
  logic [EW-1:0] ent_mem  [POOL];
  logic [LW-1:0] head_q;
  logic [EW-1:0] ent_q;
  logic          head_we;
  logic [BW-1:0] head_waddr;
  logic [LW-1:0] head_wdata;
  logic          ent_we;
  logic [PAW-1:0] ent_waddr;
  logic [EW-1:0] ent_wdata;

  logic [KEY_W-1:0]   ent_key;
  logic [COUNT_W-1:0] ent_count;
  logic [LW-1:0]      ent_link;
  logic [NBW-1:0]     nb_eff;
  logic [NBW-1:0]     rem_next;
  logic [KEY_W-1:0]   hi_pp;
  logic [KEY_W-1:0]   fold_in;
  logic               in_beat;

  assign {ent_key, ent_count, ent_link} = ent_q;
  assign in_beat  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE);

  assign out_ch.valid       = out_valid;
  assign out_ch.hit         = out_hit;
  assign out_ch.table_full  = out_full;
  assign out_ch.entry_count = out_count;

  // Folded key: key*2 + key>>32, wrapping.
  assign fold_in = {in_ch.key[KEY_W-2:0], 1'b0} + {32'd0, in_ch.key[KEY_W-1:32]};

  // Upper partial product; only its low half reaches the 64-bit result.
  assign hi_pp = fold[KEY_W-1:32] * hash_multiplier;

  // Out-of-range bucket counts act as BUCKETS.
  always_comb begin
    if (bucket_count == '0 || 32'(bucket_count) > 32'(BUCKETS)) begin
      nb_eff = NBW'(BUCKETS);
    end else begin
      nb_eff = NBW'(bucket_count);
    end
  end

  // Four restoring remainder steps per cycle.
  always_comb begin
    logic [NBW-1:0] t;
    rem_next = rem;
    for (int i = 0; i < 4; i++) begin
      t = {rem_next[NBW-2:0], prod[KEY_W-1-i]};
      if (t >= nb_eff) begin
        t = t - nb_eff;
      end
      rem_next = t;
    end
  end

  // Write port selection for both memories.
  always_comb begin
    head_we    = 1'b0;
    head_waddr = rem[BW-1:0];
    head_wdata = used;
    ent_we     = 1'b0;
    ent_waddr  = used[PAW-1:0];
    ent_wdata  = {op_key, op_init, head_q};
    if (state == S_SWEEP) begin
      head_we    = 1'b1;
      head_waddr = sweep_idx;
      head_wdata = EMPTY_LINK;
    end else if (state == S_HDAT && op_mode == MODE_INSERT) begin
      head_we = 1'b1;
      ent_we  = 1'b1;
    end else if (state == S_WCHK && op_mode == MODE_COUNT && ent_key == op_key) begin
      ent_we    = 1'b1;
      ent_waddr = node[PAW-1:0];
      ent_wdata = {ent_key, (ent_count == COUNT_MAX) ? ent_count : ent_count + 1'b1,
                   ent_link};
    end
  end

  // Memories with registered reads. Only one operation is in flight, so a
  // read that coincides with a write of the same entry is never used.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    head_q <= head_mem[rem[BW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_q <= ent_mem[node[PAW-1:0]];
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_multiplier <= MULT_RESET;
      bucket_count    <= BCOUNT_RESET;
      count_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MULT:   hash_multiplier <= cfg_data[MULT_W-1:0];
        CFG_BCOUNT: bucket_count    <= cfg_data[BCOUNT_W-1:0];
        CFG_THRESH: count_threshold <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_beat) begin
          op_mode  <= in_ch.mode;
          op_key   <= in_ch.key;
          op_init  <= in_ch.initial_count;
          fold     <= fold_in;
          res_hit  <= 1'b0;
          res_full <= (in_ch.mode == MODE_INSERT) && (used == EMPTY_LINK);
        end
      end
      S_MLO: prod <= fold[31:0] * hash_multiplier;
      S_MHI: begin
        prod[KEY_W-1:32] <= prod[KEY_W-1:32] + hi_pp[31:0];
        rem <= '0;
      end
      S_DIV: begin
        rem  <= rem_next;
        prod <= {prod[KEY_W-5:0], 4'd0};
      end
      S_HDAT: node <= head_q;
      S_WCHK: begin
        if (ent_key == op_key) begin
          res_hit <= (op_mode == MODE_COUNT) || (ent_count > count_threshold);
        end else begin
          node <= ent_link;
        end
      end
      default: ;
    endcase
  end

  // Control sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_idx  <= '0;
      sweep_item <= 1'b0;
      used       <= '0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      // The output register fills as an operation completes and empties once taken.
      if (state == S_DONE && (!out_valid || out_ch.ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_SWEEP: begin
          if (sweep_idx == BW'(BUCKETS - 1)) begin
            sweep_idx <= '0;
            used      <= '0;
            state     <= sweep_item ? S_DONE : S_IDLE;
          end else begin
            sweep_idx <= sweep_idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_beat) begin
            if (in_ch.mode == MODE_CLEAR) begin
              sweep_item <= 1'b1;
              state      <= S_SWEEP;
            end else if (in_ch.mode == MODE_INSERT && used == EMPTY_LINK) begin
              state <= S_DONE;
            end else begin
              state <= S_MLO;
            end
          end
        end
        S_MLO: state <= S_MHI;
        S_MHI: begin
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'd15) begin
            state <= S_HEAD;
          end
        end
        S_HEAD: state <= S_HDAT;
        S_HDAT: begin
          if (op_mode == MODE_INSERT) begin
            used  <= used + 1'b1;
            state <= S_DONE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          // Links always point to older slots, so every chain ends.
          state <= (node < EMPTY_LINK) ? S_WCHK : S_DONE;
        end
        S_WCHK: state <= (ent_key == op_key) ? S_DONE : S_WALK;
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            sweep_item <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload, loaded as the operation completes.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || out_ch.ready)) begin
      out_hit   <= res_hit && !sweep_item;
      out_full  <= res_full && !sweep_item;
      out_count <= ECOUNT_W'(used);
    end
  end

  // An accepted beat always starts work.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> state != S_IDLE)
    else $error("accepted beat left the block idle");

  // A result never reports both a hit and a rejected insert.
  a_hit_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_full))
    else $error("hit and table_full set together");

  // The pool fill never passes the pool size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_HDAT && op_mode == MODE_INSERT) |-> used < EMPTY_LINK)
    else $error("insert into a full pool");

  // A finished sweep leaves the pool empty.
  a_sweep_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP && sweep_idx == BW'(BUCKETS - 1)) |=> used == '0)
    else $error("pool not emptied by sweep");

endmodule

/* test/tb_chained_hash_kmer_counter_core.sv */
module tb_chained_hash_kmer_counter_core;
  import chkc_pkg::*;

  localparam int NBUCKET = 4096;
  localparam int NPOOL = 8192;
  localparam int EMPTY = NPOOL;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  chkc_in_if in_ch ();
  chkc_out_if out_ch ();

  chained_hash_kmer_counter_core uut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    logic hit;
    logic full;
    logic [ECOUNT_W-1:0] cnt;
  } lookup_result_t;

  typedef struct {
    mode_t mode;
    logic [KEY_W-1:0] key;
    logic [COUNT_W-1:0] init;
    bit typed;
    lookup_result_t res;
  } stim_row_t;

  // Mirror of the table state and registers.
  bit [MULT_W-1:0] m_mult;
  bit [BCOUNT_W-1:0] m_bcount;
  bit [COUNT_W-1:0] m_thresh;
  int m_heads[NBUCKET];
  bit [KEY_W-1:0] m_keys[NPOOL];
  bit [COUNT_W-1:0] m_counts[NPOOL];
  int m_links[NPOOL];
  int m_used;

  lookup_result_t pending_results[$];
  bit [KEY_W-1:0] recent_keys[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_full = 0;
  int n_hits = 0;
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit hold_req = 1'b0;

  function automatic int bucket_of(bit [KEY_W-1:0] key);
    bit [63:0] nb;
    bit [63:0] folded;
    nb = m_bcount;
    if (nb == 0 || nb > NBUCKET) nb = NBUCKET;
    folded = key * 64'd2 + (key >> 32);
    return int'((folded * {32'd0, m_mult}) % nb);
  endfunction

  function automatic int find_node(bit [KEY_W-1:0] key);
    int node;
    int steps;
    node = m_heads[bucket_of(key)];
    steps = 0;
    while (node < NPOOL && steps < NPOOL) begin
      if (m_keys[node] == key) return node;
      node = m_links[node];
      steps++;
    end
    return EMPTY;
  endfunction

  function automatic void clear_table();
    foreach (m_heads[i]) m_heads[i] = EMPTY;
    m_used = 0;
  endfunction

  // Applies one operation to the mirror and returns the expected beat.
  function automatic lookup_result_t count_lookup(mode_t mode, bit [KEY_W-1:0] key,
                                                  bit [COUNT_W-1:0] init);
    lookup_result_t r;
    int node;
    int b;
    r = '0;
    case (mode)
      MODE_INSERT: begin
        if (m_used >= NPOOL) begin
          r.full = 1'b1;
        end else begin
          b = bucket_of(key);
          m_keys[m_used] = key;
          m_counts[m_used] = init;
          m_links[m_used] = m_heads[b];
          m_heads[b] = m_used;
          m_used++;
        end
      end
      MODE_THRESH: begin
        node = find_node(key);
        if (node < NPOOL && m_counts[node] > m_thresh) r.hit = 1'b1;
      end
      MODE_COUNT: begin
        node = find_node(key);
        if (node < NPOOL) begin
          if (m_counts[node] != COUNT_MAX) m_counts[node]++;
          r.hit = 1'b1;
        end
      end
      default: clear_table();
    endcase
    r.cnt = m_used[ECOUNT_W-1:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offers one beat and waits for it to be taken, then records the prediction.
  task automatic send_op(mode_t mode, bit [KEY_W-1:0] key, bit [COUNT_W-1:0] init,
                         bit typed, lookup_result_t res);
    int gap;
    lookup_result_t p;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_ch.mode = mode;
    in_ch.key = key;
    in_ch.initial_count = init;
    in_ch.valid = 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    p = count_lookup(mode, key, init);
    pending_results.push_back(typed ? res : p);
    n_items++;
    if (mode == MODE_INSERT) begin
      recent_keys.push_back(key);
      if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    end
  endtask

  // Drops valid and waits until the block has returned everything and is ready.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_MULT: m_mult = val;
      CFG_BCOUNT: m_bcount = val[BCOUNT_W-1:0];
      CFG_THRESH: m_thresh = val;
      default: ;
    endcase
  endtask

  function automatic bit [KEY_W-1:0] pick_key();
    int p;
    p = $urandom_range(99);
    if (p < 50 && recent_keys.size() > 0)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    if (p < 55) return '0;
    if (p < 60) return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic bit [COUNT_W-1:0] pick_count();
    int p;
    p = $urandom_range(99);
    if (p < 10) return COUNT_MAX;
    if (p < 20) return '0;
    if (p < 40) return m_thresh + $urandom_range(2) - 1;
    if (p < 60) return $urandom_range(8);
    return $urandom();
  endfunction

  task automatic random_ops(int n, bit allow_clear);
    int p;
    mode_t mode;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 35) mode = MODE_INSERT;
      else if (p < 62) mode = MODE_THRESH;
      else if (p < 98 || !allow_clear) mode = MODE_COUNT;
      else mode = MODE_CLEAR;
      // Every 40 items, randomly choose whether to run a burst with no idling at all.
      if (i % 40 == 0) no_idle = ($urandom_range(3) == 0);
      send_op(mode, pick_key(), pick_count(), 1'b0, '0);
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare each returned beat with the oldest prediction.
  always @(posedge clk) begin
    lookup_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat hit=%0d full=%0d count=%0d", $time,
                 out_ch.hit, out_ch.table_full, out_ch.entry_count);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_ch.hit !== e.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.table_full !== e.full) begin
          $display("%0t: table_full expected %0d actual %0d", $time, e.full,
                   out_ch.table_full);
          errors++;
        end
        if (out_ch.entry_count !== e.cnt) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, e.cnt,
                   out_ch.entry_count);
          errors++;
        end
        if (e.hit) n_hits++;
        if (e.full) n_full++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_INSERT;
    in_ch.key = '0;
    in_ch.initial_count = '0;
    m_mult = MULT_RESET;
    m_bcount = BCOUNT_RESET;
    m_thresh = THRESH_RESET;
    clear_table();

    // Directed rows: typed results where they are obvious, predictor elsewhere.
    rows = '{
      '{MODE_THRESH, 64'h0, 32'h0, 1, '{1'b0, 1'b0, 14'd0}},
      '{MODE_INSERT, 64'h0, 32'h0, 1, '{1'b0, 1'b0, 14'd1}},
      '{MODE_INSERT, '1, '1, 1, '{1'b0, 1'b0, 14'd2}},
      '{MODE_THRESH, 64'h0, 32'h0, 1, '{1'b0, 1'b0, 14'd2}},
      '{MODE_COUNT, '1, 32'h0, 1, '{1'b1, 1'b0, 14'd2}},
      '{MODE_THRESH, '1, 32'h0, 1, '{1'b1, 1'b0, 14'd2}},
      '{MODE_COUNT, 64'h0, 32'h0, 1, '{1'b1, 1'b0, 14'd2}},
      '{MODE_THRESH, 64'h0, 32'h0, 1, '{1'b1, 1'b0, 14'd2}},
      '{MODE_INSERT, 64'h0, 32'h0, 1, '{1'b0, 1'b0, 14'd3}},
      '{MODE_THRESH, 64'h0, 32'h0, 1, '{1'b0, 1'b0, 14'd3}},
      '{MODE_COUNT, 64'h5555_5555_5555_5555, 32'h0, 1, '{1'b0, 1'b0, 14'd3}},
      '{MODE_INSERT, 64'h8000_0000_0000_0001, 32'h1, 0, '0},
      '{MODE_INSERT, 64'h0000_0001_0000_0000, 32'h7, 0, '0},
      '{MODE_COUNT, 64'h0000_0001_0000_0000, 32'h0, 0, '0},
      '{MODE_THRESH, 64'h8000_0000_0000_0001, 32'h0, 0, '0},
      '{MODE_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h8000_0000, 0, '0},
      '{MODE_COUNT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 0, '0},
      '{MODE_CLEAR, '1, '1, 1, '{1'b0, 1'b0, 14'd0}},
      '{MODE_COUNT, 64'h0, 32'h0, 1, '{1'b0, 1'b0, 14'd0}}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait_idle();

    foreach (rows[i])
      send_op(rows[i].mode, rows[i].key, rows[i].init, rows[i].typed, rows[i].res);
    wait_idle();

    // Default settings, with one long receiver hold-off while items keep coming.
    random_ops(60, 1'b1);
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 30; i++) send_op(MODE_INSERT, pick_key(), pick_count(), 1'b0, '0);
    no_idle = 1'b0;
    // Sender pause until everything is back, then more traffic.
    wait_idle();
    random_ops(60, 1'b1);
    wait_idle();

    // One bucket, multiplier 1: everything lands on one chain.
    write_reg(CFG_BCOUNT, 32'd1);
    write_reg(CFG_MULT, 32'd1);
    write_reg(CFG_THRESH, 32'd5);
    send_op(MODE_CLEAR, '0, '0, 1'b0, '0);
    random_ops(90, 1'b0);
    wait_idle();

    // Out-of-range bucket count of zero, largest multiplier and threshold.
    write_reg(CFG_BCOUNT, 32'd0);
    write_reg(CFG_MULT, 32'hFFFF_FFFF);
    write_reg(CFG_THRESH, 32'hFFFF_FFFF);
    random_ops(90, 1'b1);
    wait_idle();

    // Bucket count above the array size, random multiplier, entries left in place.
    write_reg(CFG_BCOUNT, 32'h1FFF);
    write_reg(CFG_MULT, $urandom() | 32'd1);
    write_reg(CFG_THRESH, $urandom_range(6));
    random_ops(80, 1'b1);
    wait_idle();
    write_reg(CFG_BCOUNT, $urandom_range(4096, 1));
    random_ops(80, 1'b1);
    wait_idle();

    // Back to the reset settings, then a clear with more traffic around it.
    write_reg(CFG_BCOUNT, 32'd4096);
    write_reg(CFG_MULT, MULT_RESET);
    write_reg(CFG_THRESH, 32'd0);
    send_op(MODE_CLEAR, '0, '0, 1'b0, '0);
    send_op(MODE_INSERT, '0, '0, 1'b0, '0);
    send_op(MODE_INSERT, '1, '1, 1'b0, '0);
    random_ops(40, 1'b0);
    send_op(MODE_CLEAR, '0, '0, 1'b1, '{1'b0, 1'b0, 14'd0});
    random_ops(30, 1'b0);

    wait_idle();
    repeat (200) @(negedge clk);
    $display("Ran %0d operations over six register settings, %0d results checked.",
             n_items, n_results);
    $display("Predicted %0d search hits and %0d rejected inserts on a full pool.",
             n_hits, n_full);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
